// ===== rtl/planar_rect_fill_engine_top_macros.svh =====
// Assertion macros shared by the frame store engine RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef PLANAR_RECT_FILL_ENGINE_TOP_MACROS_SVH
`define PLANAR_RECT_FILL_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PRF_ASSERT_IMPLY(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define PRF_ASSERT_NEXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

// ===== rtl/prf_pkg.sv =====
// Shared constants for the planar rectangle fill engine.
// Depends on nothing; imported by the top level.
package prf_pkg;

  localparam int SCREEN_WIDTH  = 640;
  localparam int SCREEN_HEIGHT = 480;
  localparam int ROW_BYTES     = (SCREEN_WIDTH + 7) / 8;
  localparam int STORE_DEPTH   = ROW_BYTES * SCREEN_HEIGHT;

  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int COL_W   = $clog2(ROW_BYTES + 1);
  localparam int ROW_W   = $clog2(SCREEN_HEIGHT + 1);
  localparam int WORD_W  = 32;
  localparam int FIELD_W = 12;
  localparam int COORD_W = 14;

  localparam logic [1:0] ACT_FILL  = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

endpackage

// ===== rtl/planar_rect_fill_engine_top.sv =====
// Planar rectangle fill engine: four 1-bit planes in one word-wide frame store.
// Depends on prf_pkg, prf_ram and planar_rect_fill_engine_top_macros.svh.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------------
//   in      | input     | in_valid/in_stall   | action, rect_*, red/green/blue, byte_address
//   out     | output    | out_valid/out_stall | intensity/red/green/blue_byte, done_res
//
// One transaction at a time; in_stall is high from acceptance until the result is
// loaded into the output register. A fill reads, merges and writes back each byte
// touched (rows x bytes per row) in the single RAM read-modify-write pass; a read
// passes through S_READ; a clear sweeps the store one word a cycle. After reset
// the same sweep runs with in_stall held high. A stalled output holds the engine
// in its final state until the result is taken.
`include "planar_rect_fill_engine_top_macros.svh"

module planar_rect_fill_engine_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           action,
  input  logic signed [prf_pkg::FIELD_W-1:0]   rect_x,
  input  logic signed [prf_pkg::FIELD_W-1:0]   rect_y,
  input  logic signed [prf_pkg::FIELD_W-1:0]   rect_w,
  input  logic signed [prf_pkg::FIELD_W-1:0]   rect_h,
  input  logic [7:0]                           red,
  input  logic [7:0]                           green,
  input  logic [7:0]                           blue,
  input  logic [15:0]                          byte_address,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [7:0]                           intensity_byte,
  output logic [7:0]                           red_byte,
  output logic [7:0]                           green_byte,
  output logic [7:0]                           blue_byte,
  output logic                                 done_res
);

  import prf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_CLEAR, S_BASE, S_FILL, S_DRAIN, S_READ, S_POST
  } state_t;

  localparam logic signed [COORD_W-1:0] SCR_W = COORD_W'(SCREEN_WIDTH);
  localparam logic signed [COORD_W-1:0] SCR_H = COORD_W'(SCREEN_HEIGHT);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);
  localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(ROW_BYTES);

  state_t state;

  logic [COL_W-1:0]  first_col, last_col, col;
  logic [2:0]        sub_first, sub_last;
  logic [ROW_W-1:0]  row_cur, row_last;
  logic [ADDR_W-1:0] base, clr_addr, wr_addr;
  logic              plane_r, plane_g, plane_b;
  logic              wr_pending;
  logic [7:0]        wr_mask;
  logic              clr_item, res_rd, res_done;

  // clip of the incoming rectangle
  logic signed [COORD_W-1:0] sx, sy, x_lo, y_lo, x_hi, y_hi, x_end, y_end;
  logic signed [COORD_W-1:0] x_last, y_last;
  logic                      clip_empty;

  // RAM ports
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;
  logic [7:0]        col_mask;
  logic              col_is_last, row_is_last, rd_in_range;

  // last covered coordinate of a clipped span
  function automatic logic signed [COORD_W-1:0] x_end_m1(input logic signed [COORD_W-1:0] v);
    x_end_m1 = v - COORD_W'(1);
  endfunction

  always_comb begin
    sx    = COORD_W'(rect_x);
    sy    = COORD_W'(rect_y);
    x_lo  = (sx < 0) ? '0 : sx;
    y_lo  = (sy < 0) ? '0 : sy;
    x_end = sx + COORD_W'(rect_w);
    y_end = sy + COORD_W'(rect_h);
    x_hi  = (x_end > SCR_W) ? SCR_W : x_end;
    y_hi  = (y_end > SCR_H) ? SCR_H : y_end;
    x_last = x_end_m1(x_hi);
    y_last = x_end_m1(y_hi);
    clip_empty = (x_hi <= x_lo) || (y_hi <= y_lo);
  end

  assign rd_in_range = {16'd0, byte_address} < 32'(STORE_DEPTH);

  assign col_is_last = (col == last_col);
  assign row_is_last = (row_cur == row_last);

  always_comb begin
    col_mask = 8'hff;
    if (col == first_col) begin
      col_mask = col_mask & (8'hff >> sub_first);
    end
    if (col_is_last) begin
      col_mask = col_mask & (8'hff << (3'd7 - sub_last));
    end
  end

  always_comb begin
    ram_re    = (state == S_FILL) || (state == S_READ);
    ram_raddr = (state == S_FILL) ? ADDR_W'(base + ADDR_W'(col)) : base;
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = wr_pending;
      ram_waddr = wr_addr;
      ram_wdata = ram_rdata | {wr_mask,
                               plane_r ? wr_mask : 8'd0,
                               plane_g ? wr_mask : 8'd0,
                               plane_b ? wr_mask : 8'd0};
    end
  end

  prf_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      clr_item   <= 1'b0;
      wr_pending <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // drop a taken result unless the next one is loaded in the same cycle
      if (out_valid && !out_stall && state != S_POST) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            case (action)
              ACT_FILL: begin
                res_rd    <= 1'b0;
                res_done  <= 1'b1;
                first_col <= COL_W'(x_lo[COORD_W-1:3]);
                last_col  <= COL_W'(x_last >>> 3);
                sub_first <= x_lo[2:0];
                sub_last  <= x_last[2:0];
                row_cur   <= ROW_W'(y_lo);
                row_last  <= ROW_W'(y_last);
                plane_r   <= (red != 8'd0);
                plane_g   <= (green != 8'd0);
                plane_b   <= (blue != 8'd0);
                state     <= clip_empty ? S_POST : S_BASE;
              end
              ACT_CLEAR: begin
                res_rd   <= 1'b0;
                res_done <= 1'b1;
                clr_addr <= '0;
                clr_item <= 1'b1;
                state    <= S_CLEAR;
              end
              ACT_READ: begin
                res_done <= 1'b1;
                base     <= ADDR_W'(byte_address);
                res_rd   <= rd_in_range;
                state    <= S_READ;
              end
              default: begin
                res_rd   <= 1'b0;
                res_done <= 1'b0;
                state    <= S_POST;
              end
            endcase
          end
        end
        S_CLEAR: begin
          clr_addr <= ADDR_W'(clr_addr + 1'b1);
          if (clr_addr == LAST_ADDR) begin
            state <= clr_item ? S_POST : S_IDLE;
          end
        end
        S_BASE: begin
          base <= ADDR_W'(32'(row_cur) * ROW_BYTES);
          col  <= first_col;
          state <= S_FILL;
        end
        S_FILL: begin
          // read this byte now, merge and write it back next cycle
          wr_pending <= 1'b1;
          wr_addr    <= ADDR_W'(base + ADDR_W'(col));
          wr_mask    <= col_mask;
          if (col_is_last) begin
            col <= first_col;
            if (row_is_last) begin
              state <= S_DRAIN;
            end else begin
              row_cur <= ROW_W'(row_cur + 1'b1);
              base    <= ADDR_W'(base + ROW_STEP);
            end
          end else begin
            col <= COL_W'(col + 1'b1);
          end
        end
        S_DRAIN: begin
          wr_pending <= 1'b0;
          state      <= S_POST;
        end
        S_READ: begin
          state <= S_POST;
        end
        S_POST: begin
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            intensity_byte <= res_rd ? ram_rdata[31:24] : 8'd0;
            red_byte       <= res_rd ? ram_rdata[23:16] : 8'd0;
            green_byte     <= res_rd ? ram_rdata[15:8]  : 8'd0;
            blue_byte      <= res_rd ? ram_rdata[7:0]   : 8'd0;
            done_res       <= res_done;
            clr_item       <= 1'b0;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `PRF_ASSERT_IMPLY(a_no_write_idle, clk, rst, state == S_IDLE, !ram_we, "write while idle")
  `PRF_ASSERT_IMPLY(a_rmw_distinct, clk, rst, ram_we && ram_re, ram_waddr != ram_raddr, "rmw overlap")
  `PRF_ASSERT_NEXT(a_out_from_post, clk, rst, state != S_POST && !out_valid, !out_valid, "stray result")
  `PRF_ASSERT_IMPLY(a_col_in_span, clk, rst, state == S_FILL, col >= first_col && col <= last_col, "column outside span")

endmodule

// ===== rtl/prf_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module prf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
